// ===== rtl/ptbe_pkg.sv =====
// ----------------------------------------------------------------------------
// ptbe_pkg
// Shared types and constants of the planar tile bitplane encoder.
// ----------------------------------------------------------------------------
package ptbe_pkg;

    // Width of the tile counter; it wraps at this many bits.
    localparam int TILE_COUNT_BITS = 19;

    localparam int PIX_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int ROW_W       = 3;
    localparam int LIMIT_W     = 19;
    localparam int DIM_W       = 10;
    localparam int TOTAL_W     = 2 * DIM_W;
    localparam int CMP_W       = (TILE_COUNT_BITS > TOTAL_W) ? TILE_COUNT_BITS : TOTAL_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = LIMIT_W;

    localparam logic [ROW_W-1:0] COL_LAST = 3'd7;
    localparam logic [ROW_W-1:0] ROW_LAST = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TILE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TILES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_TILES = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 10'd1;

    // Command kinds passed from the front to the back.
    localparam logic CMD_ROW  = 1'b0;
    localparam logic CMD_TILE = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // The back walks a tile command in nine steps: low byte, then eight high rows.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd8;

    typedef struct packed {
        logic              kind;
        logic              bank;
        logic              fin;
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] data;
    } hi_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

endpackage

// ===== rtl/ptbe_front.sv =====
// ----------------------------------------------------------------------------
// ptbe_front
// Accepts pixels, builds the plane rows, counts tiles and issues commands.
// ----------------------------------------------------------------------------
module ptbe_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [ptbe_pkg::PIX_W-1:0]     pixel,
    input  logic                           first_of_image,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ptbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptbe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           q_full,
    output logic                           q_push,
    output ptbe_pkg::cmd_t                 q_cmd,
    output ptbe_pkg::hi_wr_t               hi_wr,
    input  ptbe_pkg::release_t             bank_release
);
    import ptbe_pkg::*;

    logic [BYTE_W-1:0]          lo_reg, lo_next;
    logic [BYTE_W-1:0]          hi_reg, hi_next;
    logic [ROW_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [TILE_COUNT_BITS-1:0] tiles_reg, tiles_next;
    logic                       stopped_reg, stopped_next;
    logic                       bank_reg, bank_next;
    logic [1:0]                 busy_reg, busy_next;
    logic [LIMIT_W-1:0]         limit_reg;
    logic [DIM_W-1:0]           width_reg;
    logic [DIM_W-1:0]           height_reg;
    logic [TOTAL_W-1:0]         total;

    logic                       accept;
    logic                       work;
    logic                       row_done;
    logic                       tile_done;
    logic                       fin;
    logic [ROW_W-1:0]           eff_col;
    logic [ROW_W-1:0]           eff_row;
    logic [TILE_COUNT_BITS-1:0] eff_tiles;
    logic [TILE_COUNT_BITS-1:0] tiles_inc;
    logic                       eff_stopped;
    logic [BYTE_W-1:0]          lo_shift;
    logic [BYTE_W-1:0]          hi_shift;
    logic                       hit_limit;
    logic                       hit_total;

    assign cfg_ready = 1'b1;

    // The bank about to be filled must have been drained by the back first.
    assign full   = q_full || busy_reg[bank_reg];
    assign accept = push && !full;

    always_comb
    begin
        eff_col     = first_of_image ? '0 : col_reg;
        eff_row     = first_of_image ? '0 : row_reg;
        eff_tiles   = first_of_image ? '0 : tiles_reg;
        eff_stopped = first_of_image ? 1'b0 : stopped_reg;

        lo_shift  = {lo_reg[BYTE_W-2:0], pixel[0]};
        hi_shift  = {hi_reg[BYTE_W-2:0], pixel[1]};
        tiles_inc = TILE_COUNT_BITS'(eff_tiles + 1'b1);
        total     = TOTAL_W'(width_reg) * TOTAL_W'(height_reg);

        work      = accept && !eff_stopped;
        row_done  = work && (eff_col == COL_LAST);
        tile_done = row_done && (eff_row == ROW_LAST);

        hit_limit = (limit_reg != '0) && (CMP_W'(tiles_inc) == CMP_W'(limit_reg));
        hit_total = (total != '0) && (CMP_W'(tiles_inc) == CMP_W'(total));
        fin       = hit_limit || hit_total;

        lo_next      = lo_reg;
        hi_next      = hi_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        tiles_next   = tiles_reg;
        stopped_next = stopped_reg;
        bank_next    = bank_reg;
        busy_next    = busy_reg;

        if (accept)
        begin
            col_next     = eff_col;
            row_next     = eff_row;
            tiles_next   = eff_tiles;
            stopped_next = eff_stopped;
        end
        if (work)
        begin
            lo_next  = lo_shift;
            hi_next  = hi_shift;
            col_next = ROW_W'(eff_col + 1'b1);
        end
        if (row_done)
        begin
            row_next = ROW_W'(eff_row + 1'b1);
        end
        if (bank_release.valid)
        begin
            busy_next[bank_release.bank] = 1'b0;
        end
        if (tile_done)
        begin
            tiles_next          = tiles_inc;
            stopped_next        = fin;
            bank_next           = ~bank_reg;
            busy_next[bank_reg] = 1'b1;
        end

        q_push      = row_done;
        q_cmd.kind  = (eff_row == ROW_LAST) ? CMD_TILE : CMD_ROW;
        q_cmd.bank  = bank_reg;
        q_cmd.fin   = fin;
        q_cmd.row   = eff_row;
        q_cmd.data  = lo_shift;

        hi_wr.en   = row_done;
        hi_wr.bank = bank_reg;
        hi_wr.row  = eff_row;
        hi_wr.data = hi_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            tiles_reg   <= '0;
            stopped_reg <= 1'b0;
            bank_reg    <= 1'b0;
            busy_reg    <= '0;
            limit_reg   <= '0;
            width_reg   <= DIM_RESET;
            height_reg  <= DIM_RESET;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            tiles_reg   <= tiles_next;
            stopped_reg <= stopped_next;
            bank_reg    <= bank_next;
            busy_reg    <= busy_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_TILE_LIMIT:   limit_reg  <= cfg_data[LIMIT_W-1:0];
                    REG_WIDTH_TILES:  width_reg  <= cfg_data[DIM_W-1:0];
                    REG_HEIGHT_TILES: height_reg <= cfg_data[DIM_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Row shift registers carry only payload.
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule

// ===== rtl/ptbe_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// ptbe_cmd_queue
// Short first-in first-out queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module ptbe_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ptbe_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output ptbe_pkg::cmd_t head_cmd,
    output logic           empty
);
    import ptbe_pkg::*;

    cmd_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? QUEUE_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QUEUE_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = QUEUE_CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = QUEUE_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/ptbe_back.sv =====
// ----------------------------------------------------------------------------
// ptbe_back
// Executes commands: holds the high plane banks and drives the result register.
// ----------------------------------------------------------------------------
module ptbe_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptbe_pkg::hi_wr_t            hi_wr,
    input  logic                        q_empty,
    input  ptbe_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output ptbe_pkg::release_t          bank_release,
    output logic                        empty,
    input  logic                        pop,
    output logic [ptbe_pkg::BYTE_W-1:0] tile_byte,
    output logic                        plane,
    output logic [ptbe_pkg::ROW_W-1:0]  row,
    output logic                        tile_end,
    output logic                        finished
);
    import ptbe_pkg::*;

    // Two banks of eight high plane rows: one fills while the other drains.
    logic [BYTE_W-1:0] bank_reg [2][8];

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              plane_reg, plane_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              tend_reg, tend_next;
    logic              fin_reg, fin_next;

    logic              slot_free;
    logic              fire;
    logic              cmd_done;
    logic [ROW_W-1:0]  rd_row;

    assign slot_free = !out_valid_reg || pop;
    assign fire      = !q_empty && slot_free;
    assign rd_row    = ROW_W'(step_reg[ROW_W-1:0] - 1'b1);

    always_comb
    begin
        cmd_done = (step_reg == STEP_LAST) ||
                   ((step_reg == STEP_FIRST) && (q_cmd.kind == CMD_ROW));

        q_pop              = fire && cmd_done;
        bank_release.valid = fire && (step_reg == STEP_LAST);
        bank_release.bank  = q_cmd.bank;

        step_next = step_reg;
        if (fire)
        begin
            step_next = cmd_done ? STEP_FIRST : STEP_W'(step_reg + 1'b1);
        end

        out_valid_next = out_valid_reg;
        if (slot_free)
        begin
            out_valid_next = fire;
        end

        byte_next  = byte_reg;
        plane_next = plane_reg;
        row_next   = row_reg;
        tend_next  = tend_reg;
        fin_next   = fin_reg;
        if (fire)
        begin
            if (step_reg == STEP_FIRST)
            begin
                byte_next  = q_cmd.data;
                plane_next = 1'b0;
                row_next   = q_cmd.row;
                tend_next  = 1'b0;
                fin_next   = 1'b0;
            end
            else
            begin
                byte_next  = bank_reg[q_cmd.bank][rd_row];
                plane_next = 1'b1;
                row_next   = rd_row;
                tend_next  = (step_reg == STEP_LAST);
                fin_next   = (step_reg == STEP_LAST) && q_cmd.fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        plane_reg <= plane_next;
        row_reg   <= row_next;
        tend_reg  <= tend_next;
        fin_reg   <= fin_next;
        if (hi_wr.en)
        begin
            bank_reg[hi_wr.bank][hi_wr.row] <= hi_wr.data;
        end
    end

    assign empty     = !out_valid_reg;
    assign tile_byte = byte_reg;
    assign plane     = plane_reg;
    assign row       = row_reg;
    assign tile_end  = tend_reg;
    assign finished  = fin_reg;

    // The step counter never runs past the last high row.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("back step counter out of range");

endmodule

// ===== rtl/planar_tile_bitplane_encoder.sv =====
// ----------------------------------------------------------------------------
// planar_tile_bitplane_encoder
// Two bit per pixel planar tile encoder producing plane rows tile by tile.
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock in tile order unless full, and each
// completed tile row yields its low plane byte; the last pixel of a tile also
// yields the eight high plane bytes, which the output delivers one per clock
// after the low byte while pop is high. Results pass through the command queue
// and the output register. full rises only when the four-entry command queue
// is full or when the high plane bank about to be refilled is not yet drained;
// the banks are double-buffered, so with pop held high the input never stalls.
// Configuration is written through cfg_valid/cfg_ready, which is always ready.
// ----------------------------------------------------------------------------
module planar_tile_bitplane_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [ptbe_pkg::PIX_W-1:0]      pixel,
    input  logic                            first_of_image,
    output logic                            empty,
    input  logic                            pop,
    output logic [ptbe_pkg::BYTE_W-1:0]     tile_byte,
    output logic                            plane,
    output logic [ptbe_pkg::ROW_W-1:0]      row,
    output logic                            tile_end,
    output logic                            finished,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptbe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ptbe_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    cmd_t     push_cmd;
    cmd_t     head_cmd;
    hi_wr_t   hi_wr;
    release_t bank_release;

    ptbe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .pixel          (pixel),
        .first_of_image (first_of_image),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (push_cmd),
        .hi_wr          (hi_wr),
        .bank_release   (bank_release)
    );

    ptbe_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    ptbe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .hi_wr        (hi_wr),
        .q_empty      (q_empty),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .bank_release (bank_release),
        .empty        (empty),
        .pop          (pop),
        .tile_byte    (tile_byte),
        .plane        (plane),
        .row          (row),
        .tile_end     (tile_end),
        .finished     (finished)
    );

    // The finishing flag only ever rides on the closing byte of a tile.
    a_fin_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && finished) |-> tile_end)
        else $error("finished without tile_end");

    // A tile closes on its last high plane row.
    a_end_is_last_high: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && tile_end) |-> (plane && (row == ROW_LAST)))
        else $error("tile_end on a byte other than the last high row");

    // Nothing is emitted while the command queue has nothing to say.
    a_no_idle_output: assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty && (empty || pop)) |=> empty)
        else $error("result produced without a command");

endmodule
